### hw/rtl/phfs_pkg.sv
// Shared types, constants and saturation helpers for the particle/hole force step.
// Used by phfs_iter, phfs_ctrl, phfs_dp and the top level.
`default_nettype none
package phfs_pkg;

  localparam int MAX_HOLES  = 16;
  localparam int FRAC_BITS  = 8;
  localparam int IDX_W      = $clog2(MAX_HOLES);
  localparam int COUNT_W    = $clog2(MAX_HOLES + 1);
  localparam int HALF_SHIFT = FRAC_BITS + 12;
  localparam int TERM_FRAC  = 24;
  localparam int GAIN_SHIFT = TERM_FRAC - FRAC_BITS;
  localparam int ARITH_W    = 42;
  localparam int ACC_W      = 57;
  localparam int CNT_W      = 6;

  localparam logic [1:0] MODE_STEP = 2'd0;
  localparam logic [1:0] MODE_PUSH = 2'd1;
  localparam logic [1:0] MODE_POP  = 2'd2;
  localparam logic [1:0] MODE_NONE = 2'd3;

  localparam logic [2:0] STAT_MOVED    = 3'd0;
  localparam logic [2:0] STAT_OUTSIDE  = 3'd1;
  localparam logic [2:0] STAT_CAPTURED = 3'd2;
  localparam logic [2:0] STAT_ADDED    = 3'd3;
  localparam logic [2:0] STAT_FULL     = 3'd4;
  localparam logic [2:0] STAT_REMOVED  = 3'd5;
  localparam logic [2:0] STAT_EMPTY    = 3'd6;

  localparam logic [2:0] CFG_FIELD_W = 3'd0;
  localparam logic [2:0] CFG_FIELD_H = 3'd1;
  localparam logic [2:0] CFG_CAPTURE = 3'd2;
  localparam logic [2:0] CFG_GAIN    = 3'd3;
  localparam logic [2:0] CFG_TSCALE  = 3'd4;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } op_t;

  typedef enum logic [4:0] {
    ST_LOAD, ST_CHECK, ST_DIFF, ST_SQ, ST_SUM, ST_TEST, ST_SQRT,
    ST_DX1, ST_DX2, ST_DY1, ST_DY2, ST_GX, ST_GY,
    ST_AX1, ST_AX2, ST_AY1, ST_AY2, ST_EMIT
  } step_t;

  typedef struct packed {
    logic  start;
    logic  commit;
    step_t step;
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       out_of_field;
    logic       no_holes;
    logic       captured;
    logic       s_zero;
    logic       last_hole;
    logic       iter_done;
    logic       out_free;
  } stat_t;

  function automatic logic [23:0] sat24(input logic signed [43:0] v);
    logic [23:0] res;
    if (v > 44'sd8388607) res = 24'h7FFFFF;
    else if (v < -44'sd8388608) res = 24'h800000;
    else res = v[23:0];
    return res;
  endfunction

  function automatic logic [41:0] clamp_sum(input logic signed [42:0] v);
    logic [41:0] res;
    if (v > 43'sd1099511627776) res = 42'h100_0000_0000;
    else if (v < -43'sd1099511627776) res = 42'h300_0000_0000;
    else res = v[41:0];
    return res;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/phfs_iter.sv
// Shared iterative arithmetic unit: shift-add multiply, restoring divide, square root.
// One bit or one root digit per cycle. Depends on phfs_pkg.
`default_nettype none
module phfs_iter (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire phfs_pkg::op_t                op,
  input  wire logic [phfs_pkg::ARITH_W-1:0] opa,
  input  wire logic [phfs_pkg::ARITH_W-1:0] opb,
  output logic                              done,
  output logic [phfs_pkg::ARITH_W-1:0]      res_q,
  output logic [phfs_pkg::ACC_W-1:0]        res_acc
);
  import phfs_pkg::*;

  logic                 busy;
  logic [CNT_W-1:0]     cnt;
  op_t                  op_r;
  logic [ACC_W-1:0]     acc, acc_next;
  logic [ARITH_W-1:0]   q, q_next;
  logic [ARITH_W-1:0]   x, x_next;
  logic [ACC_W-1:0]     r2, trial;

  always_comb begin
    acc_next = acc;
    q_next   = q;
    x_next   = x;
    r2       = '0;
    trial    = '0;
    case (op_r)
      OP_MUL: begin
        acc_next = {acc[ACC_W-2:0], 1'b0} + (q[15] ? ACC_W'(x) : '0);
        q_next   = {q[ARITH_W-2:0], 1'b0};
      end
      OP_DIV: begin
        r2    = {acc[ACC_W-2:0], q[ARITH_W-1]};
        trial = ACC_W'(x);
        if (r2 >= trial) begin
          acc_next = r2 - trial;
          q_next   = {q[ARITH_W-2:0], 1'b1};
        end else begin
          acc_next = r2;
          q_next   = {q[ARITH_W-2:0], 1'b0};
        end
      end
      OP_SQRT: begin
        r2     = {acc[ACC_W-3:0], x[ARITH_W-1:ARITH_W-2]};
        trial  = ACC_W'({q, 2'b01});
        x_next = {x[ARITH_W-3:0], 2'b00};
        if (r2 >= trial) begin
          acc_next = r2 - trial;
          q_next   = {q[ARITH_W-2:0], 1'b1};
        end else begin
          acc_next = r2;
          q_next   = {q[ARITH_W-2:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        unique case (op)
          OP_MUL:  cnt <= CNT_W'(16);
          OP_DIV:  cnt <= CNT_W'(ARITH_W);
          OP_SQRT: cnt <= CNT_W'(ARITH_W / 2);
          default: cnt <= CNT_W'(1);
        endcase
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      op_r <= op;
      acc  <= '0;
      case (op)
        OP_MUL:  begin q <= opb; x <= opa; end
        OP_DIV:  begin q <= opa; x <= opb; end
        default: begin q <= '0;  x <= opa; end
      endcase
    end else if (busy) begin
      acc <= acc_next;
      q   <= q_next;
      x   <= x_next;
    end
  end

  assign res_q   = q;
  assign res_acc = acc;

endmodule
`default_nettype wire

### hw/rtl/phfs_ctrl.sv
// Sequencer for the particle/hole force step: walks holes and issues datapath steps.
// Talks to phfs_dp only through cmd_t and stat_t from phfs_pkg.
`default_nettype none
module phfs_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire phfs_pkg::stat_t stat,
  output phfs_pkg::cmd_t       cmd
);
  import phfs_pkg::*;

  typedef enum logic [17:0] {
    S_IDLE  = 18'h00001, S_CHECK = 18'h00002, S_DIFF = 18'h00004,
    S_SQ    = 18'h00008, S_SUM   = 18'h00010, S_TEST = 18'h00020,
    S_SQRT  = 18'h00040, S_DX1   = 18'h00080, S_DX2  = 18'h00100,
    S_DY1   = 18'h00200, S_DY2   = 18'h00400, S_GX   = 18'h00800,
    S_GY    = 18'h01000, S_AX1   = 18'h02000, S_AX2  = 18'h04000,
    S_AY1   = 18'h08000, S_AY2   = 18'h10000, S_EMIT = 18'h20000
  } state_t;

  state_t state, state_next;
  logic   issued, issued_next;
  logic   iter_st;
  state_t after_iter;
  step_t  iter_step;

  always_comb begin
    iter_st    = 1'b1;
    after_iter = S_IDLE;
    iter_step  = ST_SQRT;
    unique case (state)
      S_SQRT: begin iter_step = ST_SQRT; after_iter = S_DX1; end
      S_DX1:  begin iter_step = ST_DX1;  after_iter = S_DX2; end
      S_DX2:  begin iter_step = ST_DX2;  after_iter = S_DY1; end
      S_DY1:  begin iter_step = ST_DY1;  after_iter = S_DY2; end
      S_DY2:  begin
        iter_step  = ST_DY2;
        after_iter = stat.last_hole ? S_GX : S_DIFF;
      end
      S_GX:   begin iter_step = ST_GX;   after_iter = S_GY;  end
      S_GY:   begin iter_step = ST_GY;   after_iter = S_AX1; end
      S_AX1:  begin iter_step = ST_AX1;  after_iter = S_AX2; end
      S_AX2:  begin iter_step = ST_AX2;  after_iter = S_AY1; end
      S_AY1:  begin iter_step = ST_AY1;  after_iter = S_AY2; end
      S_AY2:  begin iter_step = ST_AY2;  after_iter = S_EMIT; end
      default: iter_st = 1'b0;
    endcase
  end

  always_comb begin
    state_next  = state;
    issued_next = issued;
    in_ready    = 1'b0;
    cmd.start   = 1'b0;
    cmd.commit  = 1'b0;
    cmd.step    = ST_LOAD;
    if (iter_st) begin
      cmd.step = iter_step;
      if (!issued) begin
        cmd.start   = 1'b1;
        issued_next = 1'b1;
      end else if (stat.iter_done) begin
        cmd.commit  = 1'b1;
        issued_next = 1'b0;
        state_next  = after_iter;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          in_ready   = 1'b1;
          cmd.commit = in_valid;
          if (in_valid) state_next = S_CHECK;
        end
        S_CHECK: begin
          cmd.step   = ST_CHECK;
          cmd.commit = 1'b1;
          if (stat.mode == MODE_NONE) state_next = S_IDLE;
          else if (stat.mode != MODE_STEP || stat.out_of_field) state_next = S_EMIT;
          else if (stat.no_holes) state_next = S_GX;
          else state_next = S_DIFF;
        end
        S_DIFF: begin
          cmd.step = ST_DIFF; cmd.commit = 1'b1; state_next = S_SQ;
        end
        S_SQ: begin
          cmd.step = ST_SQ; cmd.commit = 1'b1; state_next = S_SUM;
        end
        S_SUM: begin
          cmd.step = ST_SUM; cmd.commit = 1'b1; state_next = S_TEST;
        end
        S_TEST: begin
          cmd.step   = ST_TEST;
          cmd.commit = 1'b1;
          if (stat.captured) state_next = S_EMIT;
          else if (stat.s_zero) state_next = stat.last_hole ? S_GX : S_DIFF;
          else state_next = S_SQRT;
        end
        S_EMIT: begin
          cmd.step   = ST_EMIT;
          cmd.commit = stat.out_free;
          if (stat.out_free) state_next = S_IDLE;
        end
        default: state_next = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      issued <= 1'b0;
    end else begin
      state  <= state_next;
      issued <= issued_next;
    end
  end

  a_idle_not_issued: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !issued)
    else $error("unit op outstanding while idle");
  a_done_when_issued: assert property (@(posedge clk) disable iff (rst)
    stat.iter_done |-> issued)
    else $error("unit finished an op that was never issued");
  a_start_single: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> !cmd.start)
    else $error("unit started on two cycles in a row");

endmodule
`default_nettype wire

### hw/rtl/phfs_dp.sv
// Datapath: config registers, hole table, per-hole force terms, velocity and position update.
// Instantiates phfs_iter; steered by cmd_t from phfs_ctrl. Depends on phfs_pkg.
`default_nettype none
module phfs_dp (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire phfs_pkg::cmd_t             cmd,
  output phfs_pkg::stat_t                 stat,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [2:0]                 cfg_index,
  input  wire logic [15:0]                cfg_data,
  input  wire logic [1:0]                 mode,
  input  wire logic signed [23:0]         pos_x,
  input  wire logic signed [23:0]         pos_y,
  input  wire logic signed [23:0]         vel_x,
  input  wire logic signed [23:0]         vel_y,
  input  wire logic [9:0]                 elapsed_ms,
  input  wire logic [10:0]                new_hole_x,
  input  wire logic [10:0]                new_hole_y,
  input  wire logic                       new_hole_attracts,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [2:0]                      status,
  output logic signed [23:0]              next_pos_x,
  output logic signed [23:0]              next_pos_y,
  output logic signed [23:0]              next_vel_x,
  output logic signed [23:0]              next_vel_y,
  output logic [phfs_pkg::COUNT_W-1:0]    holes_held
);
  import phfs_pkg::*;

  logic [11:0] field_w, field_h;
  logic [15:0] cap_r2, gain, tscale;

  logic [1:0]         mode_r;
  logic signed [23:0] ix, iy, ivx, ivy;
  logic [9:0]         ms;
  logic [10:0]        nhx, nhy;
  logic               natt;

  logic [10:0]        hole_x [MAX_HOLES];
  logic [10:0]        hole_y [MAX_HOLES];
  logic               hole_pol [MAX_HOLES];
  logic [COUNT_W-1:0] hole_total;
  logic [IDX_W-1:0]   k;

  logic signed [21:0] dx, dy;
  logic [20:0]        ax, ay;
  logic [41:0]        sqx, sqy, s;
  logic [20:0]        r, t1;
  logic [41:0]        sum_x, sum_y;
  logic [33:0]        pm;
  logic [23:0]        px, py, vx, vy;
  logic [2:0]         stat_r;

  // per-hole differences, hole pulls toward it when it attracts
  logic signed [21:0] ixe, iye, hxe, hye, dx_n, dy_n;
  logic [41:0]        sum_x_mag, sum_y_mag;
  logic [23:0]        vx_mag, vy_mag;
  logic [31:0]        cap;

  // iterative unit
  logic               it_done;
  op_t                it_op;
  logic [ARITH_W-1:0] it_a, it_b, it_q;
  logic [ACC_W-1:0]   it_acc;

  logic [40:0]        term;
  logic [40:0]        gmag;
  logic [33:0]        amag;
  logic               commit_hole;

  assign cfg_ready = 1'b1;

  assign ixe  = $signed(ix[21:0]);
  assign iye  = $signed(iy[21:0]);
  assign hxe  = $signed({3'b0, hole_x[k], {FRAC_BITS{1'b0}}});
  assign hye  = $signed({3'b0, hole_y[k], {FRAC_BITS{1'b0}}});
  assign dx_n = hole_pol[k] ? hxe - ixe : ixe - hxe;
  assign dy_n = hole_pol[k] ? hye - iye : iye - hye;
  assign cap  = {cap_r2, {(2*FRAC_BITS){1'b0}}};

  assign sum_x_mag = sum_x[41] ? 42'(-sum_x) : sum_x;
  assign sum_y_mag = sum_y[41] ? 42'(-sum_y) : sum_y;
  assign vx_mag    = vx[23] ? 24'(-vx) : vx;
  assign vy_mag    = vy[23] ? 24'(-vy) : vy;

  assign term = it_q[40:0];
  assign gmag = it_acc[GAIN_SHIFT +: 41];
  assign amag = it_acc[16 +: 34];

  always_comb begin
    it_op = OP_MUL;
    it_a  = '0;
    it_b  = '0;
    case (cmd.step)
      ST_SQRT: begin it_op = OP_SQRT; it_a = s; end
      ST_DX1:  begin it_op = OP_DIV; it_a = ARITH_W'({ax, {HALF_SHIFT{1'b0}}}); it_b = s; end
      ST_DY1:  begin it_op = OP_DIV; it_a = ARITH_W'({ay, {HALF_SHIFT{1'b0}}}); it_b = s; end
      ST_DX2, ST_DY2: begin
        it_op = OP_DIV;
        it_a  = ARITH_W'({t1, {HALF_SHIFT{1'b0}}});
        it_b  = ARITH_W'(r);
      end
      ST_GX:  begin it_a = ARITH_W'(sum_x_mag[40:0]); it_b = ARITH_W'(gain); end
      ST_GY:  begin it_a = ARITH_W'(sum_y_mag[40:0]); it_b = ARITH_W'(gain); end
      ST_AX1: begin it_a = ARITH_W'(vx_mag); it_b = ARITH_W'(ms); end
      ST_AY1: begin it_a = ARITH_W'(vy_mag); it_b = ARITH_W'(ms); end
      ST_AX2, ST_AY2: begin it_a = ARITH_W'(pm); it_b = ARITH_W'(tscale); end
      default: ;
    endcase
  end

  phfs_iter u_iter (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.start),
    .op      (it_op),
    .opa     (it_a),
    .opb     (it_b),
    .done    (it_done),
    .res_q   (it_q),
    .res_acc (it_acc)
  );

  assign stat.mode         = mode_r;
  assign stat.out_of_field = ix[23] || iy[23] ||
                             (ix > $signed({4'b0, field_w, {FRAC_BITS{1'b0}}})) ||
                             (iy > $signed({4'b0, field_h, {FRAC_BITS{1'b0}}}));
  assign stat.no_holes     = (hole_total == '0);
  assign stat.captured     = (s < 42'(cap));
  assign stat.s_zero       = (s == '0);
  assign stat.last_hole    = (COUNT_W'(k) == hole_total - COUNT_W'(1));
  assign stat.iter_done    = it_done;
  assign stat.out_free     = !out_valid || out_ready;

  assign commit_hole = cmd.commit && cmd.step == ST_CHECK && mode_r == MODE_PUSH &&
                       hole_total < COUNT_W'(MAX_HOLES);

  always_ff @(posedge clk) begin
    if (commit_hole) begin
      hole_x[hole_total[IDX_W-1:0]]   <= nhx;
      hole_y[hole_total[IDX_W-1:0]]   <= nhy;
      hole_pol[hole_total[IDX_W-1:0]] <= natt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      field_w    <= 12'd1600;
      field_h    <= 12'd900;
      cap_r2     <= 16'd100;
      gain       <= 16'd1000;
      tscale     <= 16'd1049;
      hole_total <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_FIELD_W: field_w <= cfg_data[11:0];
          CFG_FIELD_H: field_h <= cfg_data[11:0];
          CFG_CAPTURE: cap_r2  <= cfg_data;
          CFG_GAIN:    gain    <= cfg_data;
          CFG_TSCALE:  tscale  <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.commit && cmd.step == ST_CHECK) begin
        if (commit_hole) hole_total <= hole_total + COUNT_W'(1);
        else if (mode_r == MODE_POP && hole_total != '0)
          hole_total <= hole_total - COUNT_W'(1);
      end
      if (cmd.commit && cmd.step == ST_EMIT) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      case (cmd.step)
        ST_LOAD: begin
          mode_r <= mode;
          ix <= pos_x; iy <= pos_y; ivx <= vel_x; ivy <= vel_y;
          ms <= elapsed_ms; nhx <= new_hole_x; nhy <= new_hole_y;
          natt <= new_hole_attracts;
        end
        ST_CHECK: begin
          px <= '0; py <= '0; vx <= '0; vy <= '0;
          sum_x <= '0; sum_y <= '0;
          k <= '0;
          if (mode_r == MODE_PUSH)
            stat_r <= (hole_total < COUNT_W'(MAX_HOLES)) ? STAT_ADDED : STAT_FULL;
          else if (mode_r == MODE_POP)
            stat_r <= (hole_total != '0) ? STAT_REMOVED : STAT_EMPTY;
          else
            stat_r <= stat.out_of_field ? STAT_OUTSIDE : STAT_MOVED;
        end
        ST_DIFF: begin
          dx <= dx_n;
          dy <= dy_n;
          ax <= dx_n[21] ? 21'(-dx_n) : dx_n[20:0];
          ay <= dy_n[21] ? 21'(-dy_n) : dy_n[20:0];
        end
        ST_SQ: begin
          sqx <= ax * ax;
          sqy <= ay * ay;
        end
        ST_SUM: s <= sqx + sqy;
        ST_TEST: begin
          if (stat.captured) stat_r <= STAT_CAPTURED;
          else if (stat.s_zero) k <= k + IDX_W'(1);
        end
        ST_SQRT: r <= it_q[20:0];
        ST_DX1, ST_DY1: t1 <= it_q[20:0];
        ST_DX2: sum_x <= clamp_sum(dx[21] ? $signed({sum_x[41], sum_x}) - $signed({2'b0, term})
                                          : $signed({sum_x[41], sum_x}) + $signed({2'b0, term}));
        ST_DY2: begin
          sum_y <= clamp_sum(dy[21] ? $signed({sum_y[41], sum_y}) - $signed({2'b0, term})
                                    : $signed({sum_y[41], sum_y}) + $signed({2'b0, term}));
          k <= k + IDX_W'(1);
        end
        ST_GX: vx <= sat24(sum_x[41] ? 44'(ivx) - $signed({3'b0, gmag})
                                     : 44'(ivx) + $signed({3'b0, gmag}));
        ST_GY: vy <= sat24(sum_y[41] ? 44'(ivy) - $signed({3'b0, gmag})
                                     : 44'(ivy) + $signed({3'b0, gmag}));
        ST_AX1, ST_AY1: pm <= it_acc[33:0];
        ST_AX2: px <= sat24(vx[23] ? 44'(ix) - $signed({10'b0, amag})
                                   : 44'(ix) + $signed({10'b0, amag}));
        ST_AY2: py <= sat24(vy[23] ? 44'(iy) - $signed({10'b0, amag})
                                   : 44'(iy) + $signed({10'b0, amag}));
        ST_EMIT: begin
          status     <= stat_r;
          next_pos_x <= px;
          next_pos_y <= py;
          next_vel_x <= vx;
          next_vel_y <= vy;
          holes_held <= hole_total;
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

### hw/rtl/particle_hole_force_step_top.sv
// Top level of the particle/hole force step: sequencer plus datapath.
// Depends on phfs_pkg, phfs_ctrl, phfs_dp (which holds phfs_iter).
//
//   channel | handshake               | payload
//   --------+-------------------------+-------------------------------------------
//   in      | in_valid / in_ready     | mode, pos/vel x,y, elapsed_ms, new hole
//   out     | out_valid / out_ready   | status, next pos/vel x,y, holes_held
//   cfg     | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// Hole push, pop and out-of-field items go from check straight to emit; unused mode 3
// returns to idle after the check with no output. A particle step walks the holes: per
// hole the setup states diff, square, sum and test, then a 21-digit root and four 42-bit
// divides; after the walk six 16-bit multiplies for gain and advance. A capture ends the
// walk at that hole; a hole at zero distance skips the root and the divides.
// One item is in work at a time; a full output register holds the sequencer in emit.
// A finished item waits in the output register; the next item is taken meanwhile.
// Reset (rst, synchronous) empties the hole table and loads the default registers.
`default_nettype none
module particle_hole_force_step_top (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [1:0]               mode,
  input  wire logic signed [23:0]       pos_x,
  input  wire logic signed [23:0]       pos_y,
  input  wire logic signed [23:0]       vel_x,
  input  wire logic signed [23:0]       vel_y,
  input  wire logic [9:0]               elapsed_ms,
  input  wire logic [10:0]              new_hole_x,
  input  wire logic [10:0]              new_hole_y,
  input  wire logic                     new_hole_attracts,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [2:0]                    status,
  output logic signed [23:0]            next_pos_x,
  output logic signed [23:0]            next_pos_y,
  output logic signed [23:0]            next_vel_x,
  output logic signed [23:0]            next_vel_y,
  output logic [phfs_pkg::COUNT_W-1:0]  holes_held,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [2:0]               cfg_index,
  input  wire logic [15:0]              cfg_data
);
  import phfs_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  phfs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  phfs_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .stat              (stat),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .mode              (mode),
    .pos_x             (pos_x),
    .pos_y             (pos_y),
    .vel_x             (vel_x),
    .vel_y             (vel_y),
    .elapsed_ms        (elapsed_ms),
    .new_hole_x        (new_hole_x),
    .new_hole_y        (new_hole_y),
    .new_hole_attracts (new_hole_attracts),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .status            (status),
    .next_pos_x        (next_pos_x),
    .next_pos_y        (next_pos_y),
    .next_vel_x        (next_vel_x),
    .next_vel_y        (next_vel_y),
    .holes_held        (holes_held)
  );

endmodule
`default_nettype wire
